@@ hdl/plc_pkg.sv @@
// ----------------------------------------------------------------------------
// plc_pkg
// Shared constants, codes and types of the piecewise linear correction block.
// ----------------------------------------------------------------------------
package plc_pkg;

  localparam int PLC_MAX_POINTS = 16;
  localparam int PLC_VALUE_BITS = 16;
  localparam int PLC_INDEX_BITS = 4;
  localparam int PLC_CFG_BITS   = 5;

  localparam logic PLC_ACT_STORE   = 1'b0;
  localparam logic PLC_ACT_CORRECT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_DONE
  } plc_state_e;

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_MUL,
    MD_ABS,
    MD_DIV,
    MD_FIN
  } plc_md_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } plc_md_stat_t;

endpackage

@@ hdl/plc_req_if.sv @@
// ----------------------------------------------------------------------------
// plc_req_if
// Request channel: store a calibration point or correct a sample.
// ----------------------------------------------------------------------------
interface plc_req_if
  import plc_pkg::*;
#(
  parameter int VALUE_BITS = PLC_VALUE_BITS
);
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [PLC_INDEX_BITS-1:0]     point_index;
  logic signed [VALUE_BITS-1:0]  point_x;
  logic signed [VALUE_BITS-1:0]  point_y;
  logic signed [VALUE_BITS-1:0]  sample;

  modport source (output valid, action, point_index, point_x, point_y, sample,
                  input ready);
  modport sink   (input valid, action, point_index, point_x, point_y, sample,
                  output ready);
endinterface

@@ hdl/plc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// plc_rsp_if
// Result channel: corrected value and match flag.
// ----------------------------------------------------------------------------
interface plc_rsp_if
  import plc_pkg::*;
#(
  parameter int VALUE_BITS = PLC_VALUE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_BITS-1:0]  corrected;
  logic                          matched;

  modport source (output valid, corrected, matched, input ready);
  modport sink   (input valid, corrected, matched, output ready);
endinterface

@@ hdl/plc_muldiv.sv @@
// ----------------------------------------------------------------------------
// plc_muldiv
// Bit-serial unit: num = y0*a + y1*b by shift-add, then num / d by restoring
// division, one bit per cycle, truncated toward zero.
// ----------------------------------------------------------------------------
module plc_muldiv
  import plc_pkg::*;
#(
  parameter int VALUE_BITS = PLC_VALUE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [VALUE_BITS-1:0]  y0_i,
  input  logic signed [VALUE_BITS-1:0]  y1_i,
  input  logic [VALUE_BITS-1:0]         a_i,
  input  logic [VALUE_BITS-1:0]         b_i,
  input  logic [VALUE_BITS-1:0]         d_i,
  output logic signed [VALUE_BITS-1:0]  quot_o,
  output plc_md_stat_t                  stat_o
);

  localparam int PW  = 2 * VALUE_BITS + 2;
  localparam int STW = $clog2(VALUE_BITS);
  localparam logic [STW-1:0] STEP_LAST = STW'(VALUE_BITS - 1);

  plc_md_state_e state_q, state_d;

  logic signed [VALUE_BITS-1:0] y0_q, y1_q;
  logic [VALUE_BITS-1:0]        a_q, b_q, d_q;
  logic [VALUE_BITS-1:0]        rem_q, lo_q;
  logic [PW-1:0]                acc_q;
  logic [STW-1:0]               step_q;
  logic                         neg_q;

  logic [PW-1:0]         acc_d;
  logic [PW-1:0]         term0, term1;
  logic [PW-1:0]         mag;
  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   diff;
  logic                  fits;
  logic                  step_end;

  assign step_end = (step_q == '0);

  assign term0 = a_q[VALUE_BITS-1] ? {{(PW-VALUE_BITS){y0_q[VALUE_BITS-1]}}, y0_q} : '0;
  assign term1 = b_q[VALUE_BITS-1] ? {{(PW-VALUE_BITS){y1_q[VALUE_BITS-1]}}, y1_q} : '0;
  assign acc_d = {acc_q[PW-2:0], 1'b0} + term0 + term1;
  assign mag   = acc_q[PW-1] ? (~acc_q + PW'(1)) : acc_q;
  assign trial = {rem_q, lo_q[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, d_q};
  assign fits  = (trial >= {1'b0, d_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      MD_IDLE: if (start_i) state_d = MD_MUL;
      MD_MUL:  if (step_end) state_d = MD_ABS;
      MD_ABS:  state_d = MD_DIV;
      MD_DIV:  if (step_end) state_d = MD_FIN;
      MD_FIN:  state_d = MD_IDLE;
      default: state_d = MD_IDLE;
    endcase
  end

  always_comb begin
    stat_o.busy = (state_q != MD_IDLE);
    stat_o.done = (state_q == MD_FIN);
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      MD_IDLE: begin
        if (start_i) begin
          y0_q   <= y0_i;
          y1_q   <= y1_i;
          a_q    <= a_i;
          b_q    <= b_i;
          d_q    <= d_i;
          acc_q  <= '0;
          step_q <= STEP_LAST;
        end
      end
      MD_MUL: begin
        acc_q  <= acc_d;
        a_q    <= {a_q[VALUE_BITS-2:0], 1'b0};
        b_q    <= {b_q[VALUE_BITS-2:0], 1'b0};
        step_q <= step_q - STW'(1);
      end
      MD_ABS: begin
        neg_q  <= acc_q[PW-1];
        rem_q  <= mag[2*VALUE_BITS-1:VALUE_BITS];
        lo_q   <= mag[VALUE_BITS-1:0];
        step_q <= STEP_LAST;
      end
      MD_DIV: begin
        rem_q  <= fits ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
        lo_q   <= {lo_q[VALUE_BITS-2:0], fits};
        step_q <= step_q - STW'(1);
      end
      default: begin
      end
    endcase
  end

  assign quot_o = neg_q ? (~lo_q + VALUE_BITS'(1)) : lo_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == MD_IDLE)
    else $error("start while unit busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.done |=> !stat_o.done)
    else $error("done held longer than one cycle");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == MD_DIV |-> rem_q < d_q)
    else $error("partial remainder not below divisor");

endmodule

@@ hdl/piecewise_linear_correction.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_correction
// Calibration table of (x, y) points and linear interpolation of samples.
//
//   channel  dir  handshake          payload
//   req_i    in   valid/ready        action, point_index, point_x, point_y, sample
//   rsp_o    out  valid/ready        corrected, matched
//   cfg      in   cfg_we_i           cfg_wdata_i -> points_in_use
//
// A store writes the table and gives no result. A correct with two or more
// points in use scans the table, one table read per cycle, and on a match
// then runs the serial multiplier and the serial divider. Reset clears
// control and points_in_use; the table is not cleared. A stalled result sits
// in the output register while the next request is already taken; the engine
// holds its result until that frees.
// ----------------------------------------------------------------------------
module piecewise_linear_correction
  import plc_pkg::*;
#(
  parameter int MAX_POINTS = PLC_MAX_POINTS,
  parameter int VALUE_BITS = PLC_VALUE_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [PLC_CFG_BITS-1:0]  cfg_wdata_i,
  plc_req_if.sink                  req_i,
  plc_rsp_if.source                rsp_o
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int CMPW  = (CW > PLC_CFG_BITS) ? CW : PLC_CFG_BITS;

  plc_state_e state_q, state_d;

  logic [PLC_CFG_BITS-1:0] points_q;

  logic signed [VALUE_BITS-1:0] x_mem [MAX_POINTS];
  logic signed [VALUE_BITS-1:0] y_mem [MAX_POINTS];

  logic signed [VALUE_BITS-1:0] rx_q, ry_q, px_q, py_q, s_q;
  logic signed [VALUE_BITS-1:0] res_q, ocorr_q;
  logic                         rmatch_q, omatch_q, ovalid_q;
  logic [CW-1:0]                cnt_q, addr_q;
  logic                         rdv_q, rdv_first_q, rdv_last_q;

  logic          req_ready, accept, store_we, correct_in;
  logic          rd_en, match, md_start, out_load;
  logic [CW-1:0] cnt_in;

  logic [VALUE_BITS-1:0]        md_a, md_b, md_d;
  logic signed [VALUE_BITS-1:0] md_quot;
  plc_md_stat_t                 md_stat;

  assign accept     = req_i.valid && req_ready;
  assign correct_in = accept && (req_i.action == PLC_ACT_CORRECT);
  assign store_we   = accept && (req_i.action == PLC_ACT_STORE) &&
                      (32'(req_i.point_index) < MAX_POINTS);

  assign cnt_in = (CMPW'(points_q) > CMPW'(MAX_POINTS)) ? CW'(MAX_POINTS)
                                                        : CW'(points_q);

  assign match = (state_q == ST_SCAN) && rdv_q && !rdv_first_q &&
                 (s_q >= px_q) && (s_q < rx_q);

  assign md_a = rx_q - s_q;
  assign md_b = s_q - px_q;
  assign md_d = rx_q - px_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      points_q    <= '0;
      ovalid_q    <= 1'b0;
      rdv_q       <= 1'b0;
      rdv_first_q <= 1'b0;
      rdv_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      rdv_q       <= rd_en;
      rdv_first_q <= rd_en && (addr_q == '0);
      rdv_last_q  <= rd_en && (addr_q == cnt_q - CW'(1));
      if (cfg_we_i) begin
        points_q <= cfg_wdata_i;
      end
      if (out_load) begin
        ovalid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (correct_in) begin
          state_d = (cnt_in < CW'(2)) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match) begin
          state_d = ST_CALC;
        end else if (rdv_q && rdv_last_q) begin
          state_d = ST_DONE;
        end
      end
      ST_CALC: if (md_stat.done) state_d = ST_DONE;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = (state_q == ST_IDLE);
    rd_en     = (state_q == ST_SCAN) && (addr_q < cnt_q);
    md_start  = match;
    out_load  = (state_q == ST_DONE) && (!ovalid_q || rsp_o.ready);
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      x_mem[IDX_W'(req_i.point_index)] <= req_i.point_x;
      y_mem[IDX_W'(req_i.point_index)] <= req_i.point_y;
    end
    if (rd_en) begin
      rx_q <= x_mem[addr_q[IDX_W-1:0]];
      ry_q <= y_mem[addr_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (correct_in) begin
      s_q      <= req_i.sample;
      cnt_q    <= cnt_in;
      addr_q   <= '0;
      res_q    <= req_i.sample;
      rmatch_q <= 1'b0;
    end
    if (rd_en) begin
      addr_q <= addr_q + CW'(1);
    end
    if (state_q == ST_SCAN && rdv_q && !match) begin
      px_q <= rx_q;
      py_q <= ry_q;
      if (rdv_last_q) begin
        res_q    <= s_q;
        rmatch_q <= 1'b0;
      end
    end
    if (state_q == ST_CALC && md_stat.done) begin
      res_q    <= md_quot;
      rmatch_q <= 1'b1;
    end
    if (out_load) begin
      ocorr_q  <= res_q;
      omatch_q <= rmatch_q;
    end
  end

  plc_muldiv #(
    .VALUE_BITS (VALUE_BITS)
  ) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .y0_i    (py_q),
    .y1_i    (ry_q),
    .a_i     (md_a),
    .b_i     (md_b),
    .d_i     (md_d),
    .quot_o  (md_quot),
    .stat_o  (md_stat)
  );

  assign req_i.ready     = req_ready;
  assign rsp_o.valid     = ovalid_q;
  assign rsp_o.corrected = ocorr_q;
  assign rsp_o.matched   = omatch_q;

  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_stat.done |-> state_q == ST_CALC)
    else $error("unit result outside calculation phase");

  a_ready_unit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready |-> !md_stat.busy)
    else $error("request taken while unit busy");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> addr_q <= cnt_q)
    else $error("scan address past points in use");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for piecewise_linear_correction. A queued driver
// offers store and correct requests with random gaps, and a monitor takes
// results with random stalls and one long hold-off. Each accepted request
// runs through a table-based predictor in the bench. Each result is
// compared in order with the oldest predicted correction. The bench steps
// through several points_in_use settings, the extremes included.
// ----------------------------------------------------------------------------
module tb;
  import plc_pkg::*;

  localparam int ITEMS          = 1700;
  localparam int SETTLE_CYCLES  = 100;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_AT        = 300;
  localparam int HOLD_CYCLES    = 600;

  typedef struct packed {
    logic                             action;
    logic [PLC_INDEX_BITS-1:0]        point_index;
    logic signed [PLC_VALUE_BITS-1:0] point_x;
    logic signed [PLC_VALUE_BITS-1:0] point_y;
    logic signed [PLC_VALUE_BITS-1:0] sample;
  } plc_request_t;

  typedef struct packed {
    logic signed [PLC_VALUE_BITS-1:0] corrected;
    logic                             matched;
  } plc_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                             cfg_we    = 1'b0;
  logic [PLC_CFG_BITS-1:0]          cfg_wdata = '0;
  logic                             req_valid = 1'b0;
  logic                             req_action = PLC_ACT_STORE;
  logic [PLC_INDEX_BITS-1:0]        req_index = '0;
  logic signed [PLC_VALUE_BITS-1:0] req_x = '0;
  logic signed [PLC_VALUE_BITS-1:0] req_y = '0;
  logic signed [PLC_VALUE_BITS-1:0] req_sample = '0;
  logic                             rsp_ready = 1'b0;

  plc_req_if req_ch ();
  plc_rsp_if rsp_ch ();

  assign req_ch.valid       = req_valid;
  assign req_ch.action      = req_action;
  assign req_ch.point_index = req_index;
  assign req_ch.point_x     = req_x;
  assign req_ch.point_y     = req_y;
  assign req_ch.sample      = req_sample;
  assign rsp_ch.ready       = rsp_ready;

  piecewise_linear_correction uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  plc_request_t req_backlog[$];
  plc_result_t  corrections_due[$];

  logic signed [PLC_VALUE_BITS-1:0] x_cal [PLC_MAX_POINTS];
  logic signed [PLC_VALUE_BITS-1:0] y_cal [PLC_MAX_POINTS];
  int unsigned points_cfg = 0;

  bit          idle_on      = 1'b1;
  int unsigned items_queued = 0;
  int unsigned fail_count   = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic void calibrate_or_correct(plc_request_t rq);
    int          n;
    longint      s, x0, x1, y0, y1, num, q;
    plc_result_t res;
    if (rq.action == PLC_ACT_STORE) begin
      x_cal[rq.point_index] = rq.point_x;
      y_cal[rq.point_index] = rq.point_y;
      return;
    end
    n = (points_cfg > PLC_MAX_POINTS) ? PLC_MAX_POINTS : points_cfg;
    s = rq.sample;
    res.corrected = rq.sample;
    res.matched = 1'b0;
    for (int i = 0; i + 1 < n; i++) begin
      x0 = x_cal[i];
      x1 = x_cal[i+1];
      if (!res.matched && s >= x0 && s < x1) begin
        y0 = y_cal[i];
        y1 = y_cal[i+1];
        num = y0 * (x1 - s) + y1 * (s - x0);
        q = num / (x1 - x0);
        res.corrected = PLC_VALUE_BITS'(q);
        res.matched = 1'b1;
      end
    end
    corrections_due.push_back(res);
  endfunction

  plc_request_t offered;
  int unsigned  src_wait;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid  <= 1'b0;
      req_action <= PLC_ACT_STORE;
      req_index  <= '0;
      req_x      <= '0;
      req_y      <= '0;
      req_sample <= '0;
      src_wait = 0;
    end else begin
      if (req_valid && req_ch.ready) begin
        calibrate_or_correct(offered);
      end
      if (!req_valid || req_ch.ready) begin
        if (src_wait != 0) begin
          src_wait--;
          req_valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          offered = req_backlog.pop_front();
          req_valid  <= 1'b1;
          req_action <= offered.action;
          req_index  <= offered.point_index;
          req_x      <= offered.point_x;
          req_y      <= offered.point_y;
          req_sample <= offered.sample;
          src_wait = idle_on ? $urandom_range(0, 8) : 0;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  plc_result_t want;
  int unsigned sink_wait;
  int unsigned hold_left;
  bit          hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
      sink_wait = 0;
      hold_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ready) begin
        results_seen++;
        if (corrections_due.size() == 0) begin
          $error("result with no request outstanding: corrected %0d matched %0b",
                 rsp_ch.corrected, rsp_ch.matched);
          fail_count++;
        end else begin
          want = corrections_due.pop_front();
          if (rsp_ch.corrected !== want.corrected) begin
            $error("corrected: expected %0d, actual %0d", want.corrected, rsp_ch.corrected);
            fail_count++;
          end
          if (rsp_ch.matched !== want.matched) begin
            $error("matched: expected %0b, actual %0b", want.matched, rsp_ch.matched);
            fail_count++;
          end
        end
        sink_wait = idle_on ? $urandom_range(0, 8) : 0;
      end
      // hold off long enough for the block to back up into the request side
      if (!hold_done && results_seen >= HOLD_AT && req_backlog.size() > 20) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (sink_wait != 0) begin
        sink_wait--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_valid && req_ch.ready) || (rsp_ch.valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_store(input int slot, input int x, input int y);
    plc_request_t rq;
    rq.action      = PLC_ACT_STORE;
    rq.point_index = PLC_INDEX_BITS'(slot);
    rq.point_x     = PLC_VALUE_BITS'(x);
    rq.point_y     = PLC_VALUE_BITS'(y);
    rq.sample      = PLC_VALUE_BITS'($urandom);
    req_backlog.push_back(rq);
    items_queued++;
  endtask

  task automatic push_correct(input int s);
    plc_request_t rq;
    rq.action      = PLC_ACT_CORRECT;
    rq.point_index = PLC_INDEX_BITS'($urandom);
    rq.point_x     = PLC_VALUE_BITS'($urandom);
    rq.point_y     = PLC_VALUE_BITS'($urandom);
    rq.sample      = PLC_VALUE_BITS'(s);
    req_backlog.push_back(rq);
    items_queued++;
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (req_backlog.size() != 0 || req_valid || corrections_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_points(input int unsigned v);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= PLC_CFG_BITS'(v);
    points_cfg = v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int tx [PLC_MAX_POINTS];
    int ty [PLC_MAX_POINTS];
    int n, cfg, lo, hi, k, t, phase, sz;
    bit sorted;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_correct(-32768);
    push_correct(32767);
    push_store(0, -32768, 32767);
    push_store(1, 0, -32768);
    push_store(2, 0, 100);
    push_store(3, 32767, -32768);
    drain();
    set_points(1);
    push_correct(0);
    drain();
    set_points(4);
    push_correct(-32768);
    push_correct(-1);
    push_correct(0);
    push_correct(1);
    push_correct(32766);
    push_correct(32767);
    push_correct(12345);
    drain();

    phase = 0;
    while (items_queued < ITEMS) begin
      case (phase)
        0: cfg = 31;
        1: cfg = 16;
        2: cfg = 2;
        3: cfg = 0;
        default: begin
          case ($urandom_range(0, 9))
            0: cfg = 0;
            1: cfg = 1;
            2: cfg = 2;
            3: cfg = PLC_MAX_POINTS;
            4: cfg = $urandom_range(PLC_MAX_POINTS + 1, 31);
            default: cfg = $urandom_range(3, PLC_MAX_POINTS - 1);
          endcase
        end
      endcase
      set_points(cfg);
      n = (cfg > PLC_MAX_POINTS) ? PLC_MAX_POINTS : cfg;

      sorted = ($urandom_range(0, 7) != 0);
      for (int i = 0; i < n; i++) begin
        tx[i] = $urandom_range(0, 65535) - 32768;
        if ($urandom_range(0, 15) == 0) begin
          ty[i] = $urandom_range(0, 1) ? 32767 : -32768;
        end else begin
          ty[i] = $urandom_range(0, 65535) - 32768;
        end
      end
      if (sorted) begin
        for (int i = 1; i < n; i++) begin
          for (int j = i; j > 0 && tx[j-1] > tx[j]; j--) begin
            t = tx[j];
            tx[j] = tx[j-1];
            tx[j-1] = t;
          end
        end
      end
      for (int i = 0; i < n; i++) begin
        push_store(i, tx[i], ty[i]);
      end
      if (n >= 2) begin
        lo = (tx[0] < tx[n-1]) ? tx[0] : tx[n-1];
        hi = (tx[0] < tx[n-1]) ? tx[n-1] : tx[0];
      end

      idle_on = ($urandom_range(0, 2) != 0);
      sz = $urandom_range(40, 160);
      for (int j = 0; j < sz; j++) begin
        if ($urandom_range(0, 11) == 0) begin
          k = $urandom_range(0, PLC_MAX_POINTS - 1);
          if (k < n) begin
            ty[k] = $urandom_range(0, 65535) - 32768;
            push_store(k, tx[k], ty[k]);
          end else begin
            push_store(k, $urandom, $urandom);
          end
        end else if (n < 2) begin
          push_correct($urandom);
        end else begin
          case ($urandom_range(0, 9))
            6: push_correct(tx[$urandom_range(0, n - 1)]);
            7: push_correct(tx[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : -1));
            8: push_correct($urandom_range(0, 1) ? 32767 : -32768);
            9: push_correct($urandom);
            default: push_correct(lo + $urandom_range(0, hi - lo));
          endcase
        end
      end
      drain();
      phase++;
    end

    if (fail_count == 0 && corrections_due.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
